FILE: rtl/core/tlcc_pkg.sv
// shared constants, keyword tables and types of the tab line command classifier
package tlcc_pkg;

  localparam int NUMBER_WIDTH_DEF = 32;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] FIELD_MAX = 4'd15;
  localparam logic [3:0] KW_POS_MAX = 4'd15;

  localparam int KW_COUNT = 12;

  // keyword indexes, in priority order
  localparam logic [3:0] KW_HELLO   = 4'd0;
  localparam logic [3:0] KW_BYEBYE  = 4'd1;
  localparam logic [3:0] KW_EXIT    = 4'd2;
  localparam logic [3:0] KW_REF     = 4'd3;
  localparam logic [3:0] KW_REDIR   = 4'd4;
  localparam logic [3:0] KW_REQUEST = 4'd5;
  localparam logic [3:0] KW_LOAD    = 4'd6;
  localparam logic [3:0] KW_LEFT    = 4'd7;
  localparam logic [3:0] KW_ASK     = 4'd8;
  localparam logic [3:0] KW_ANS     = 4'd9;
  localparam logic [3:0] KW_GROUP   = 4'd10;
  localparam logic [3:0] KW_ASSIGN  = 4'd11;

  // words are right-justified, first character in the highest used byte
  localparam logic [63:0] KW_WORD [KW_COUNT] = '{
    "hello", "byebye", "exit", "ref", "redir", "request",
    "load", "left", "ask", "ans", "group", "assign"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd6, 4'd4, 4'd3, 4'd5, 4'd7, 4'd4, 4'd4, 4'd3, 4'd3, 4'd5, 4'd6
  };

  localparam logic [3:0] MT_UNKNOWN   = 4'd0;
  localparam logic [3:0] MT_INCORRECT = 4'd1;
  localparam logic [3:0] MT_HELLO     = 4'd2;
  localparam logic [3:0] MT_BYEBYE    = 4'd3;
  localparam logic [3:0] MT_EXIT      = 4'd4;
  localparam logic [3:0] MT_REF       = 4'd5;
  localparam logic [3:0] MT_REDIR     = 4'd6;
  localparam logic [3:0] MT_REQUEST   = 4'd7;
  localparam logic [3:0] MT_LOAD      = 4'd8;
  localparam logic [3:0] MT_LEFT      = 4'd9;
  localparam logic [3:0] MT_ASK       = 4'd10;
  localparam logic [3:0] MT_ANS       = 4'd11;
  localparam logic [3:0] MT_GROUP     = 4'd12;
  localparam logic [3:0] MT_ASSIGN    = 4'd13;

  localparam logic [2:0] TRUE_LEN    = 3'd4;
  localparam logic [2:0] TRUE_BROKEN = 3'd7;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [63:0] w;
    w = KW_WORD[k] << (8 * (8 - int'(KW_LEN[k])));
    return w[63 - 8 * int'(pos) -: 8];
  endfunction

  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0: ch = 8'h74;
      2'd1: ch = 8'h72;
      2'd2: ch = 8'h75;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  typedef struct packed {
    logic [3:0]  field_index;
    logic [3:0]  kw_pos;
    logic [11:0] kw_hits;
    logic [2:0]  true_prog;
    logic [1:0]  num_ok;
  } scan_stat_t;

  typedef struct packed {
    logic [3:0]         msg_type;
    logic [3:0]         field_count;
    logic signed [31:0] first_number;
    logic signed [31:0] second_number;
    logic               hello_group;
  } result_t;

endpackage

FILE: rtl/core/tlcc_if.sv
// request and result channel interfaces of the classifier
interface tlcc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink (input valid, input mode, input char_byte, output ready);
endinterface

interface tlcc_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         msg_type;
  logic [3:0]         field_count;
  logic signed [31:0] first_number;
  logic signed [31:0] second_number;
  logic               hello_group;

  modport source (output valid, output msg_type, output field_count, output first_number,
                  output second_number, output hello_group, input ready);
  modport sink (input valid, input msg_type, input field_count, input first_number,
                input second_number, input hello_group, output ready);
endinterface

FILE: rtl/core/tab_line_command_classifier_top.sv
// Tab line command classifier, top level. Takes one request per clock: a character byte
// (mode 0) or an end-of-line marker (mode 1), and gives one result per end-of-line marker
// with the line's type, field count, the numbers of fields 1 and 2 and the hello group
// flag. Each byte is held for one request before it reaches the scanner, so a carriage
// return directly ahead of the marker can be dropped; the scanner then updates its field,
// keyword, number and true word registers together. Once the marker is accepted, a pending
// line end is registered and the result is then loaded into the output register, and
// requests keep flowing at one per clock as long as results are taken; a result that waits
// with the output register still full holds further requests back.
module tab_line_command_classifier_top import tlcc_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  tlcc_in_if.sink   cmd,
  tlcc_out_if.source res
);

  logic               held_valid;
  logic [7:0]         held_byte;
  logic               line_started;
  logic               fin_valid;
  logic               fin_started;
  logic               res_valid;
  result_t            res_data;

  logic               can_load;
  logic               finish;
  logic               accept;
  logic               take;
  scan_stat_t         stat;
  logic signed [31:0] first_value, second_value;
  result_t            result;

  assign can_load  = !res_valid || res.ready;
  assign finish    = fin_valid && can_load;
  assign cmd.ready = !fin_valid || can_load;
  assign accept    = cmd.valid && cmd.ready;
  // the held byte is scanned when the next request arrives, unless it is a final CR
  assign take      = accept && held_valid && !(cmd.mode && held_byte == CH_CR);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      line_started <= 1'b0;
      fin_valid    <= 1'b0;
      fin_started  <= 1'b0;
    end else begin
      if (accept) begin
        held_valid   <= !cmd.mode;
        line_started <= !cmd.mode;
      end
      if (accept && cmd.mode) begin
        fin_valid   <= 1'b1;
        fin_started <= line_started;
      end else if (finish) begin
        fin_valid <= 1'b0;
      end
    end
    if (accept && !cmd.mode) begin
      held_byte <= cmd.char_byte;
    end
  end

  tlcc_scan #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .clear        (finish),
    .c            (held_byte),
    .stat         (stat),
    .first_value  (first_value),
    .second_value (second_value)
  );

  tlcc_classify u_classify (
    .stat         (stat),
    .started      (fin_started),
    .first_value  (first_value),
    .second_value (second_value),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (finish) begin
      res_data <= result;
    end
  end

  assign res.valid         = res_valid;
  assign res.msg_type      = res_data.msg_type;
  assign res.field_count   = res_data.field_count;
  assign res.first_number  = res_data.first_number;
  assign res.second_number = res_data.second_number;
  assign res.hello_group   = res_data.hello_group;

  // a held byte and a pending line end never coexist
  assert property (@(posedge clk) disable iff (rst) !(held_valid && fin_valid))
    else $error("held byte alongside pending line end");

  // an accepted end of line always leaves a pending finish
  assert property (@(posedge clk) disable iff (rst) (accept && cmd.mode) |=> fin_valid)
    else $error("line end not registered");

  // an empty line gives an incorrect result with no fields
  assert property (@(posedge clk) disable iff (rst)
    (finish && !fin_started) |=> (res_valid && res_data.msg_type == MT_INCORRECT &&
                                  res_data.field_count == 4'd0))
    else $error("empty line not reported as incorrect");

  // the scanner is back at its reset state after every finished line
  assert property (@(posedge clk) disable iff (rst)
    finish |=> (stat.field_index == 4'd0 && stat.kw_pos == 4'd0 && stat.kw_hits == '1))
    else $error("scanner not cleared after line end");

endmodule

FILE: rtl/core/tlcc_number.sv
// decimal field parser with leading whitespace, sign and saturation
module tlcc_number import tlcc_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               step,
  input  logic [7:0]         c,
  output logic               ok,
  output logic signed [31:0] value
);

  localparam int NW = NUMBER_WIDTH;
  localparam logic [2:0] PH_AWAIT  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_DEAD   = 3'd4;

  localparam logic [NW-1:0] CAP = {1'b1, {(NW-1){1'b0}}};
  localparam logic [NW+3:0] CAP_W = {4'd0, CAP};

  logic [2:0]    phase, phase_next;
  logic          neg, neg_next;
  logic [NW-1:0] acc, acc_next;
  logic          is_digit, is_ws;
  logic [NW+3:0] acc_w, wide;
  logic [NW-1:0] sv;
  logic [NW+31:0] ext;

  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign acc_w    = {4'd0, acc};
  // acc * 10 + digit, never above ten times the cap plus nine
  assign wide     = (acc_w << 3) + (acc_w << 1) + {{NW{1'b0}}, c[3:0]};

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    if (step) begin
      unique case (phase)
        PH_AWAIT: begin
          if (is_ws) begin
            phase_next = PH_AWAIT;
          end else if (c == CH_PLUS || c == CH_MINUS) begin
            neg_next   = (c == CH_MINUS);
            phase_next = PH_SIGNED;
          end else if (is_digit) begin
            phase_next = PH_DIGITS;
            acc_next   = {{(NW-4){1'b0}}, c[3:0]};
          end else begin
            phase_next = PH_DEAD;
          end
        end
        PH_SIGNED: begin
          if (is_digit) begin
            phase_next = PH_DIGITS;
            acc_next   = {{(NW-4){1'b0}}, c[3:0]};
          end else begin
            phase_next = PH_DEAD;
          end
        end
        PH_DIGITS: begin
          if (!is_digit) begin
            phase_next = PH_DONE;
          end else if (wide > CAP_W) begin
            acc_next = CAP;
          end else begin
            acc_next = wide[NW-1:0];
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase <= PH_AWAIT;
      neg   <= 1'b0;
    end else begin
      phase <= phase_next;
      neg   <= neg_next;
    end
    acc <= acc_next;
  end

  assign ok = (phase == PH_DIGITS) || (phase == PH_DONE);

  always_comb begin
    if (neg) begin
      sv = (~acc) + {{(NW-1){1'b0}}, 1'b1};
    end else if (acc == CAP) begin
      sv = CAP - {{(NW-1){1'b0}}, 1'b1};
    end else begin
      sv = acc;
    end
  end

  assign ext   = {{32{sv[NW-1]}}, sv};
  assign value = ext[31:0];

endmodule

FILE: rtl/core/tlcc_scan.sv
// per-byte line scanner: field index, keyword match, number and true word tracking
module tlcc_scan import tlcc_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               clear,
  input  logic [7:0]         c,
  output scan_stat_t         stat,
  output logic signed [31:0] first_value,
  output logic signed [31:0] second_value
);

  logic [3:0]  field_index, field_index_next;
  logic [3:0]  kw_pos, kw_pos_next;
  logic [11:0] kw_hits, kw_hits_next;
  logic [2:0]  true_prog, true_prog_next;
  logic [11:0] close_mask, char_mask;
  logic        is_tab;
  logic [1:0]  num_step, num_ok;

  assign is_tab = (c == CH_TAB);

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      close_mask[k] = (kw_pos == KW_LEN[k]);
      char_mask[k]  = (kw_pos < KW_LEN[k]) && (kw_char(k, kw_pos[2:0]) == c);
    end
  end

  always_comb begin
    field_index_next = field_index;
    kw_pos_next      = kw_pos;
    kw_hits_next     = kw_hits;
    true_prog_next   = true_prog;
    if (take) begin
      if (is_tab) begin
        if (field_index == 4'd0) begin
          kw_hits_next = kw_hits & close_mask;
        end
        if (field_index != FIELD_MAX) begin
          field_index_next = field_index + 4'd1;
        end
      end else if (field_index == 4'd0) begin
        kw_hits_next = kw_hits & char_mask;
        if (kw_pos != KW_POS_MAX) begin
          kw_pos_next = kw_pos + 4'd1;
        end
      end else if (field_index == 4'd2) begin
        if (true_prog < TRUE_LEN && true_char(true_prog[1:0]) == c) begin
          true_prog_next = true_prog + 3'd1;
        end else begin
          true_prog_next = TRUE_BROKEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      field_index <= 4'd0;
      kw_pos      <= 4'd0;
      kw_hits     <= '1;
      true_prog   <= 3'd0;
    end else begin
      field_index <= field_index_next;
      kw_pos      <= kw_pos_next;
      kw_hits     <= kw_hits_next;
      true_prog   <= true_prog_next;
    end
  end

  assign num_step[0] = take && !is_tab && (field_index == 4'd1);
  assign num_step[1] = take && !is_tab && (field_index == 4'd2);

  tlcc_number #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_num1 (
    .clk   (clk),
    .rst   (rst),
    .clear (clear),
    .step  (num_step[0]),
    .c     (c),
    .ok    (num_ok[0]),
    .value (first_value)
  );

  tlcc_number #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_num2 (
    .clk   (clk),
    .rst   (rst),
    .clear (clear),
    .step  (num_step[1]),
    .c     (c),
    .ok    (num_ok[1]),
    .value (second_value)
  );

  assign stat.field_index = field_index;
  assign stat.kw_pos      = kw_pos;
  assign stat.kw_hits     = kw_hits;
  assign stat.true_prog   = true_prog;
  assign stat.num_ok      = num_ok;

endmodule

FILE: rtl/core/tlcc_classify.sv
// end of line decision: keyword, field count check and number selection
module tlcc_classify import tlcc_pkg::*; (
  input  scan_stat_t         stat,
  input  logic               started,
  input  logic signed [31:0] first_value,
  input  logic signed [31:0] second_value,
  output result_t            result
);

  always_comb begin
    logic [11:0] eff_hits;
    logic        found;
    logic [3:0]  hit;
    logic [3:0]  count;
    logic        count_ok;
    logic [3:0]  kw_type;
    logic [3:0]  mt;

    // a line without a tab closes the keyword at end of line
    for (int k = 0; k < KW_COUNT; k++) begin
      eff_hits[k] = stat.kw_hits[k] &&
                    ((stat.field_index != 4'd0) || (stat.kw_pos == KW_LEN[k]));
    end

    found = 1'b0;
    hit   = 4'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (eff_hits[k]) begin
        found = 1'b1;
        hit   = 4'(k);
      end
    end

    count = (stat.field_index == FIELD_MAX) ? FIELD_MAX : stat.field_index + 4'd1;

    unique case (hit)
      KW_HELLO:   begin kw_type = MT_HELLO;   count_ok = (count == 4'd3); end
      KW_BYEBYE:  begin kw_type = MT_BYEBYE;  count_ok = 1'b1;            end
      KW_EXIT:    begin kw_type = MT_EXIT;    count_ok = 1'b1;            end
      KW_REF:     begin kw_type = MT_REF;     count_ok = (count == 4'd4); end
      KW_REDIR:   begin kw_type = MT_REDIR;   count_ok = (count == 4'd3); end
      KW_REQUEST: begin kw_type = MT_REQUEST; count_ok = (count == 4'd2); end
      KW_LOAD:    begin kw_type = MT_LOAD;    count_ok = (count == 4'd3); end
      KW_LEFT:    begin kw_type = MT_LEFT;    count_ok = (count == 4'd2); end
      KW_ASK:     begin kw_type = MT_ASK;     count_ok = (count >= 4'd2); end
      KW_ANS:     begin kw_type = MT_ANS;     count_ok = (count >= 4'd2); end
      KW_GROUP:   begin kw_type = MT_GROUP;   count_ok = (count == 4'd2); end
      KW_ASSIGN:  begin kw_type = MT_ASSIGN;  count_ok = (count == 4'd3); end
      default:    begin kw_type = MT_UNKNOWN; count_ok = 1'b1;            end
    endcase

    if (!found) begin
      mt = MT_UNKNOWN;
    end else if (!count_ok) begin
      mt = MT_INCORRECT;
    end else begin
      mt = kw_type;
    end

    result.msg_type      = MT_INCORRECT;
    result.field_count   = 4'd0;
    result.first_number  = '0;
    result.second_number = '0;
    result.hello_group   = 1'b0;

    if (started) begin
      result.field_count = count;
      result.msg_type    = mt;
      case (mt) inside
        MT_REQUEST, MT_LEFT, MT_GROUP: begin
          if (stat.num_ok[0]) begin
            result.first_number = first_value;
          end else begin
            result.msg_type = MT_INCORRECT;
          end
        end
        MT_LOAD: begin
          if (stat.num_ok[0] && stat.num_ok[1]) begin
            result.first_number  = first_value;
            result.second_number = second_value;
          end else begin
            result.msg_type = MT_INCORRECT;
          end
        end
        MT_HELLO: begin
          result.hello_group = (stat.true_prog == TRUE_LEN);
        end
        default: begin
          result.msg_type = mt;
        end
      endcase
    end
  end

endmodule
